### design/tkbcd_pkg.sv
package tkbcd_pkg;

  // Channel count and derived widths
  localparam int CHANNELS = 4;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PORTS    = 4;
  localparam int PORT_W   = 2;

  // Field widths
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int THR_W   = 16;
  localparam int AVG_W   = 16;
  localparam int LVL_W   = 8;
  localparam int KEY_W   = 3;
  localparam int MEM_W   = SUM_W + THR_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_LEVEL   = 1'd1;
  localparam logic [CNT_W-1:0]     CALIB_FRAMES_RST = 16'd16;
  localparam logic [LVL_W-1:0]     SENS_LEVEL_RST   = 8'd10;

  // Divide by 100 through a reciprocal multiply, exact for 16-bit averages
  localparam int PCT_SCALE   = 100;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + PCT_SCALE - 1) / PCT_SCALE);
  localparam int PROD_W = AVG_W + RECIP_W;
  localparam int PQ_W   = PROD_W - RECIP_SHIFT;
  localparam int MQ_W   = PQ_W + LVL_W;
  localparam int TSUM_W = MQ_W + 1;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_THR,
    S_DONE
  } state_e;

endpackage

### design/tkbcd_ram.sv
module tkbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tkbcd_div.sv
module tkbcd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tkbcd_pkg::SUM_W-1:0]  dividend_i,
  input  logic [tkbcd_pkg::CNT_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [tkbcd_pkg::SUM_W-1:0]  quotient_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [tkbcd_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [tkbcd_pkg::CNT_W-1:0]         rem_q, rem_d;
  logic [tkbcd_pkg::SUM_W-1:0]         quo_q, quo_d;
  logic [tkbcd_pkg::CNT_W-1:0]         dsr_q, dsr_d;
  logic [tkbcd_pkg::CNT_W:0]           rem_sh;
  logic [tkbcd_pkg::CNT_W:0]           trial;
  logic                                fits;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem_q, quo_q[tkbcd_pkg::SUM_W-1]};
  assign trial  = rem_sh - {1'b0, dsr_q};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[tkbcd_pkg::CNT_W-1:0] : rem_sh[tkbcd_pkg::CNT_W-1:0];
      quo_d = {quo_q[tkbcd_pkg::SUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tkbcd_pkg::DIV_CNT_W'(tkbcd_pkg::SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/tkbcd_thr.sv
module tkbcd_thr (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tkbcd_pkg::AVG_W-1:0]  avg_i,
  input  logic [tkbcd_pkg::LVL_W-1:0]  level_i,
  output logic                         valid_o,
  output logic [tkbcd_pkg::THR_W-1:0]  thr_o
);

  logic                                v1_q, v2_q;
  logic [tkbcd_pkg::PROD_W-1:0]        prod_q;
  logic [tkbcd_pkg::AVG_W-1:0]         avg_q;
  logic [tkbcd_pkg::THR_W-1:0]         thr_q, thr_d;
  logic [tkbcd_pkg::PQ_W-1:0]          pct;
  logic [tkbcd_pkg::MQ_W-1:0]          margin;
  logic [tkbcd_pkg::TSUM_W-1:0]        total;

  // Stage 2: margin = (avg / 100) * level, add, saturate
  always_comb begin
    pct    = prod_q[tkbcd_pkg::PROD_W-1:tkbcd_pkg::RECIP_SHIFT];
    margin = tkbcd_pkg::MQ_W'(pct) * tkbcd_pkg::MQ_W'(level_i);
    total  = tkbcd_pkg::TSUM_W'(avg_q) + tkbcd_pkg::TSUM_W'(margin);
    if (total[tkbcd_pkg::TSUM_W-1:tkbcd_pkg::THR_W] != '0) begin
      thr_d = '1;
    end else begin
      thr_d = total[tkbcd_pkg::THR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  // Stage 1: reciprocal multiply for the divide by 100
  always_ff @(posedge clk_i) begin
    prod_q <= tkbcd_pkg::PROD_W'(avg_i) * tkbcd_pkg::PROD_W'(tkbcd_pkg::RECIP);
    avg_q  <= avg_i;
    thr_q  <= thr_d;
  end

  assign valid_o = v2_q;
  assign thr_o   = thr_q;

endmodule

### design/touch_key_baseline_calibrate_detect_top.sv
// A plain frame runs a read and an evaluate step for each channel, then a done step.
// The frame that completes calibration adds, per channel, the 32-step shared divider
// and the 2-stage threshold multiply.
// One frame is in work at a time; the next is taken as soon as the block is back in idle,
// even while the last result word still waits at the output register.
// Reset (rst_ni low, asynchronous) clears control, frame count and entry valid bits.
module touch_key_baseline_calibrate_detect_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [tkbcd_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [tkbcd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [tkbcd_pkg::CNT_W-1:0]       count_0_i,
  input  logic [tkbcd_pkg::CNT_W-1:0]       count_1_i,
  input  logic [tkbcd_pkg::CNT_W-1:0]       count_2_i,
  input  logic [tkbcd_pkg::CNT_W-1:0]       count_3_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tkbcd_pkg::KEY_W-1:0]       key_index_o,
  output logic                              calibrating_o,
  output logic                              calib_done_o
);

  // Configuration registers
  logic [tkbcd_pkg::CNT_W-1:0]  calib_frames_q;
  logic [tkbcd_pkg::LVL_W-1:0]  level_q;

  // Frame control
  tkbcd_pkg::state_e            state_q, state_d;
  logic [tkbcd_pkg::CNT_W-1:0]  frames_seen_q;
  logic                         accum_q, complete_q;
  logic [tkbcd_pkg::CH_W-1:0]   ch_q;
  logic [tkbcd_pkg::KEY_W-1:0]  key_q;
  logic [tkbcd_pkg::SUM_W-1:0]  sum_q;
  logic [tkbcd_pkg::CNT_W-1:0]  cnt_q [tkbcd_pkg::PORTS];

  // Entry valid bits: an entry not yet written reads as zero
  logic [tkbcd_pkg::CHANNELS-1:0] sum_vld_q;
  logic [tkbcd_pkg::CHANNELS-1:0] thr_vld_q;

  // Output register
  logic                         out_valid_q;
  logic [tkbcd_pkg::KEY_W-1:0]  out_key_q;
  logic                         out_calibrating_q;
  logic                         out_done_q;

  // Datapath
  logic                         in_take;
  logic                         frame_accum, frame_complete;
  logic [tkbcd_pkg::CNT_W-1:0]  frames_next;
  logic [tkbcd_pkg::CNT_W-1:0]  cnt_sel;
  logic [tkbcd_pkg::MEM_W-1:0]  ram_rdata;
  logic [tkbcd_pkg::MEM_W-1:0]  ram_wdata;
  logic                         ram_we, ram_re;
  logic [tkbcd_pkg::SUM_W-1:0]  sum_eff, sum_new;
  logic [tkbcd_pkg::THR_W-1:0]  thr_eff, thr_cmp;
  logic                         last_ch;
  logic                         hit;
  logic                         eval_cmp;
  logic                         out_load;
  logic                         div_start, div_done;
  logic [tkbcd_pkg::SUM_W-1:0]  div_quo;
  logic                         thr_start, thr_valid;
  logic [tkbcd_pkg::THR_W-1:0]  thr_res;

  assign in_stall_o = (state_q != tkbcd_pkg::S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // Frame decision at accept: restart, accumulate, or pass through
  assign frames_next    = frames_seen_q + 1'b1;
  assign frame_accum    = !op_i && (frames_seen_q < calib_frames_q);
  assign frame_complete = frame_accum && (frames_next == calib_frames_q);

  // Per-channel read-modify-write of {sum, threshold}
  assign cnt_sel = cnt_q[tkbcd_pkg::PORT_W'(ch_q)];
  assign sum_eff = sum_vld_q[ch_q] ? ram_rdata[tkbcd_pkg::MEM_W-1:tkbcd_pkg::THR_W] : '0;
  assign thr_eff = thr_vld_q[ch_q] ? ram_rdata[tkbcd_pkg::THR_W-1:0] : '0;
  assign sum_new = sum_eff + tkbcd_pkg::SUM_W'(cnt_sel);
  assign last_ch = (ch_q == tkbcd_pkg::CH_W'(tkbcd_pkg::CHANNELS - 1));

  // Compare against the new threshold on the completing frame
  assign thr_cmp = (state_q == tkbcd_pkg::S_THR) ? thr_res : thr_eff;
  assign hit     = (cnt_sel > thr_cmp);

  tkbcd_ram #(
    .WIDTH (tkbcd_pkg::MEM_W),
    .DEPTH (tkbcd_pkg::CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ch_q),
    .rdata_o (ram_rdata)
  );

  // The divider latches its operands on start, in the evaluate cycle,
  // so it takes the freshly added sum straight from the adder.
  tkbcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (calib_frames_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  tkbcd_thr u_thr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (thr_start),
    .avg_i   (div_quo[tkbcd_pkg::AVG_W-1:0]),
    .level_i (level_q),
    .valid_o (thr_valid),
    .thr_o   (thr_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tkbcd_pkg::S_IDLE: begin
        if (in_take) begin
          state_d = tkbcd_pkg::S_READ;
        end
      end
      tkbcd_pkg::S_READ: begin
        state_d = tkbcd_pkg::S_EVAL;
      end
      tkbcd_pkg::S_EVAL: begin
        if (complete_q) begin
          state_d = tkbcd_pkg::S_DIV;
        end else if (last_ch) begin
          state_d = tkbcd_pkg::S_DONE;
        end else begin
          state_d = tkbcd_pkg::S_READ;
        end
      end
      tkbcd_pkg::S_DIV: begin
        if (div_done) begin
          state_d = tkbcd_pkg::S_THR;
        end
      end
      tkbcd_pkg::S_THR: begin
        if (thr_valid) begin
          state_d = last_ch ? tkbcd_pkg::S_DONE : tkbcd_pkg::S_READ;
        end
      end
      tkbcd_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = tkbcd_pkg::S_IDLE;
        end
      end
      default: state_d = tkbcd_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = {sum_new, thr_eff};
    div_start = 1'b0;
    thr_start = 1'b0;
    eval_cmp  = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      tkbcd_pkg::S_IDLE: begin
      end
      tkbcd_pkg::S_READ: begin
        ram_re = 1'b1;
      end
      tkbcd_pkg::S_EVAL: begin
        if (complete_q) begin
          div_start = 1'b1;
        end else begin
          // write back only when the frame adds to the sums
          eval_cmp = 1'b1;
          ram_we   = accum_q;
        end
      end
      tkbcd_pkg::S_DIV: begin
        thr_start = div_done;
      end
      tkbcd_pkg::S_THR: begin
        if (thr_valid) begin
          eval_cmp  = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = {sum_q, thr_res};
        end
      end
      tkbcd_pkg::S_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tkbcd_pkg::S_IDLE;
      calib_frames_q <= tkbcd_pkg::CALIB_FRAMES_RST;
      level_q        <= tkbcd_pkg::SENS_LEVEL_RST;
      frames_seen_q  <= '0;
      accum_q        <= 1'b0;
      complete_q     <= 1'b0;
      ch_q           <= '0;
      key_q          <= '0;
      sum_vld_q      <= '0;
      thr_vld_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          tkbcd_pkg::CFG_CALIB_FRAMES: calib_frames_q <= cfg_wdata_i;
          tkbcd_pkg::CFG_SENS_LEVEL:   level_q <= cfg_wdata_i[tkbcd_pkg::LVL_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_take) begin
        accum_q    <= frame_accum;
        complete_q <= frame_complete;
        ch_q       <= '0;
        key_q      <= '0;
        if (op_i) begin
          // restart: drop all sums, keep thresholds
          frames_seen_q <= '0;
          sum_vld_q     <= '0;
        end else if (frame_accum) begin
          frames_seen_q <= frames_next;
        end
      end

      if (ram_we) begin
        sum_vld_q[ch_q] <= 1'b1;
        thr_vld_q[ch_q] <= 1'b1;
      end

      if (eval_cmp) begin
        if (key_q == '0 && hit) begin
          key_q <= tkbcd_pkg::KEY_W'(ch_q) + 1'b1;
        end
        if (!last_ch) begin
          ch_q <= ch_q + 1'b1;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cnt_q[0] <= count_0_i;
      cnt_q[1] <= count_1_i;
      cnt_q[2] <= count_2_i;
      cnt_q[3] <= count_3_i;
    end
    if (state_q == tkbcd_pkg::S_EVAL) begin
      sum_q <= sum_new;
    end
    if (out_load) begin
      out_key_q         <= key_q;
      out_calibrating_q <= (frames_seen_q < calib_frames_q);
      out_done_q        <= complete_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_index_o   = out_key_q;
  assign calibrating_o = out_calibrating_q;
  assign calib_done_o  = out_done_q;

endmodule

### dv/touch_key_baseline_calibrate_detect_top_tb.sv
module touch_key_baseline_calibrate_detect_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Frame kinds carried on op_i
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Longest stretch with no word moving on either side before the run is called hung.
  // Worst legal case: receiver hold plus a calibration-completing frame plus long gaps.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_PRINTS     = 100;

  typedef logic [tkbcd_pkg::CNT_W-1:0] cnt_set_t [tkbcd_pkg::CHANNELS];

  typedef struct {
    logic     op;
    cnt_set_t cnt;
  } touch_frame_t;

  typedef struct packed {
    logic [tkbcd_pkg::KEY_W-1:0] key;
    logic                        calibrating;
    logic                        done;
  } key_word_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [tkbcd_pkg::CFG_IDX_W-1:0]  cfg_addr_i;
  logic [tkbcd_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic                             op_i;
  logic [tkbcd_pkg::CNT_W-1:0]      count_0_i;
  logic [tkbcd_pkg::CNT_W-1:0]      count_1_i;
  logic [tkbcd_pkg::CNT_W-1:0]      count_2_i;
  logic [tkbcd_pkg::CNT_W-1:0]      count_3_i;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [tkbcd_pkg::KEY_W-1:0]      key_index_o;
  logic                             calibrating_o;
  logic                             calib_done_o;

  touch_key_baseline_calibrate_detect_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .count_0_i     (count_0_i),
    .count_1_i     (count_1_i),
    .count_2_i     (count_2_i),
    .count_3_i     (count_3_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_index_o   (key_index_o),
    .calibrating_o (calibrating_o),
    .calib_done_o  (calib_done_o)
  );

  // Mirror of the block's registers and calibration state
  logic [tkbcd_pkg::CNT_W-1:0] cal_frames   = tkbcd_pkg::CALIB_FRAMES_RST;
  logic [tkbcd_pkg::LVL_W-1:0] sens_level   = tkbcd_pkg::SENS_LEVEL_RST;
  logic [tkbcd_pkg::CNT_W-1:0] frames_taken = '0;
  logic [tkbcd_pkg::SUM_W-1:0] chan_sum [tkbcd_pkg::CHANNELS] = '{default: '0};
  logic [tkbcd_pkg::THR_W-1:0] press_thr [tkbcd_pkg::CHANNELS] = '{default: '0};

  key_word_t pending_keys [$];

  int errors        = 0;
  int frames_sent   = 0;
  int quiet_cycles  = 0;
  int hold_request  = 0;
  bit burst_mode    = 1'b0;

  // Receiver-side pacing state
  int rx_hold_left  = 0;
  int rx_run_left   = 0;
  bit rx_stalling   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: advance calibration state by one frame and return the key word
  // the block must produce for it.
  // ---------------------------------------------------------------------------
  function automatic key_word_t next_key_word(input touch_frame_t f);
    key_word_t                   w;
    logic [tkbcd_pkg::SUM_W-1:0] avg;
    logic [tkbcd_pkg::SUM_W-1:0] thr;
    w = '0;
    if (f.op == OP_RESTART) begin
      // restart: clear count and sums, keep thresholds, no accumulation
      frames_taken = '0;
      foreach (chan_sum[i]) chan_sum[i] = '0;
    end else if (frames_taken < cal_frames) begin
      frames_taken = frames_taken + 1'b1;
      for (int i = 0; i < tkbcd_pkg::CHANNELS; i++) begin
        chan_sum[i] = chan_sum[i] + tkbcd_pkg::SUM_W'(f.cnt[i]);
      end
      if (frames_taken == cal_frames) begin
        for (int i = 0; i < tkbcd_pkg::CHANNELS; i++) begin
          avg = chan_sum[i] / tkbcd_pkg::SUM_W'(cal_frames);
          thr = avg + (avg / tkbcd_pkg::PCT_SCALE) * tkbcd_pkg::SUM_W'(sens_level);
          press_thr[i] = (thr > tkbcd_pkg::SUM_W'(16'hFFFF)) ? 16'hFFFF :
                         thr[tkbcd_pkg::THR_W-1:0];
        end
        w.done = 1'b1;
      end
    end
    // lowest channel above its threshold wins: scan high to low, keep the last hit
    for (int i = tkbcd_pkg::CHANNELS - 1; i >= 0; i--) begin
      if (f.cnt[i] > press_thr[i]) w.key = tkbcd_pkg::KEY_W'(i + 1);
    end
    w.calibrating = (frames_taken < cal_frames);
    return w;
  endfunction

  function automatic logic [tkbcd_pkg::CNT_W-1:0] clip16(input int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[tkbcd_pkg::CNT_W-1:0];
  endfunction

  function automatic touch_frame_t make_frame(input logic op, input int c0, input int c1,
                                              input int c2, input int c3);
    touch_frame_t f;
    f.op     = op;
    f.cnt[0] = clip16(c0);
    f.cnt[1] = clip16(c1);
    f.cnt[2] = clip16(c2);
    f.cnt[3] = clip16(c3);
    return f;
  endfunction

  function automatic touch_frame_t random_frame(input logic op);
    touch_frame_t f;
    f.op = op;
    foreach (f.cnt[i]) f.cnt[i] = tkbcd_pkg::CNT_W'($urandom_range(0, 65535));
    return f;
  endfunction

  // Calibration frame: each channel jitters around its resting level
  function automatic touch_frame_t around_base(input cnt_set_t base);
    touch_frame_t f;
    f.op = OP_SAMPLE;
    foreach (f.cnt[i]) f.cnt[i] = clip16(int'(base[i]) + int'($urandom_range(0, 40)) - 20);
    return f;
  endfunction

  // Detection frame: mostly counts right at the thresholds, some below, some anywhere
  function automatic touch_frame_t probe_frame();
    touch_frame_t f;
    int           r;
    f.op = ($urandom_range(0, 19) == 0) ? OP_RESTART : OP_SAMPLE;
    foreach (f.cnt[i]) begin
      r = $urandom_range(0, 99);
      if (r < 50) f.cnt[i] = clip16(int'(press_thr[i]) + int'($urandom_range(0, 4)) - 2);
      else if (r < 75) f.cnt[i] = tkbcd_pkg::CNT_W'($urandom_range(0, int'(press_thr[i])));
      else f.cnt[i] = tkbcd_pkg::CNT_W'($urandom_range(0, 65535));
    end
    return f;
  endfunction

  // Idle length: mostly none or short, now and then long; none at all in burst mode
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR %0t ns: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer one frame, hold it until accepted, then queue its key word.
  // Valid stays high across back-to-back frames; drop it only to open a gap.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input touch_frame_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= f.op;
    count_0_i  <= f.cnt[0];
    count_1_i  <= f.cnt[1];
    count_2_i  <= f.cnt[2];
    count_3_i  <= f.cnt[3];
    do @(posedge clk_i); while (in_stall_o);
    pending_keys.push_back(next_key_word(f));
    frames_sent++;
  endtask

  // Drop valid and wait until every queued key word has come back
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(input logic [tkbcd_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= tkbcd_pkg::CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == tkbcd_pkg::CFG_CALIB_FRAMES) cal_frames = tkbcd_pkg::CNT_W'(val);
    else sens_level = tkbcd_pkg::LVL_W'(val);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed corners: zero thresholds, extreme settings, exact threshold edges,
  // restart, completed calibration, zero and maximum frame counts.
  task automatic test_corner_frames();
    // thresholds still zero after reset: any nonzero count is a press
    send_frame(make_frame(OP_SAMPLE, 0, 0, 0, 0));
    send_frame(make_frame(OP_SAMPLE, 0, 0, 0, 1));
    send_frame(make_frame(OP_SAMPLE, 65535, 65535, 65535, 65535));
    settle_idle();

    // two-frame calibration at the widest margin; channel 0 saturates
    write_reg(tkbcd_pkg::CFG_CALIB_FRAMES, 2);
    write_reg(tkbcd_pkg::CFG_SENS_LEVEL, 255);
    send_frame(make_frame(OP_RESTART, 65535, 65535, 65535, 65535));
    send_frame(make_frame(OP_SAMPLE, 65535, 65535, 100, 0));
    send_frame(make_frame(OP_SAMPLE, 65535, 65535, 100, 0));
    // one above channel 2's threshold, then exactly at it
    send_frame(make_frame(OP_SAMPLE, 65535, 0, 356, 1));
    send_frame(make_frame(OP_SAMPLE, 65535, 65535, 355, 0));
    // calibration complete: these must not move the thresholds
    send_frame(make_frame(OP_SAMPLE, 0, 0, 0, 1));
    send_frame(make_frame(OP_SAMPLE, 9, 9, 9, 9));
    settle_idle();

    // single-frame calibration, zero margin: threshold equals the average
    write_reg(tkbcd_pkg::CFG_SENS_LEVEL, 0);
    write_reg(tkbcd_pkg::CFG_CALIB_FRAMES, 1);
    send_frame(make_frame(OP_RESTART, 0, 0, 0, 0));
    send_frame(make_frame(OP_SAMPLE, 1000, 2000, 3000, 4000));
    send_frame(make_frame(OP_SAMPLE, 1000, 2001, 3000, 4000));
    send_frame(make_frame(OP_SAMPLE, 1001, 2001, 3001, 4001));
    settle_idle();

    // zero frame count: calibration never runs, thresholds hold
    write_reg(tkbcd_pkg::CFG_CALIB_FRAMES, 0);
    send_frame(make_frame(OP_RESTART, 1000, 2000, 3000, 4001));
    send_frame(make_frame(OP_SAMPLE, 5000, 5000, 5000, 5000));
    send_frame(make_frame(OP_SAMPLE, 1000, 2000, 3000, 4001));
    settle_idle();

    // largest frame count: stays in calibration throughout
    write_reg(tkbcd_pkg::CFG_CALIB_FRAMES, 65535);
    write_reg(tkbcd_pkg::CFG_SENS_LEVEL, 100);
    send_frame(make_frame(OP_RESTART, 0, 0, 0, 0));
    send_frame(random_frame(OP_SAMPLE));
    send_frame(random_frame(OP_SAMPLE));
    settle_idle();
  endtask

  // Random sessions: new settings, restart, a calibration run around per-channel
  // resting levels, then detection frames close to the fresh thresholds.
  // Some sessions skip the restart or break off calibration.
  task automatic test_random_sessions(input int target);
    int       stop_at;
    int       cal;
    int       r;
    int       runs;
    bit       broke_off;
    cnt_set_t base;
    stop_at = frames_sent + target;
    while (frames_sent < stop_at) begin
      settle_idle();
      r = $urandom_range(0, 99);
      if (r < 65) cal = $urandom_range(1, 6);
      else if (r < 88) cal = $urandom_range(7, 24);
      else if (r < 93) cal = 0;
      else cal = $urandom_range(40, 90);
      if ($urandom_range(0, 9) != 0) write_reg(tkbcd_pkg::CFG_CALIB_FRAMES, cal);
      r = $urandom_range(0, 99);
      if (r < 10) write_reg(tkbcd_pkg::CFG_SENS_LEVEL, 0);
      else if (r < 20) write_reg(tkbcd_pkg::CFG_SENS_LEVEL, 255);
      else if (r < 85) write_reg(tkbcd_pkg::CFG_SENS_LEVEL, $urandom_range(0, 255));
      burst_mode = ($urandom_range(0, 7) == 0);

      if ($urandom_range(0, 6) != 0) send_frame(random_frame(OP_RESTART));
      foreach (base[i]) begin
        r = $urandom_range(0, 3);
        case (r)
          0: base[i] = tkbcd_pkg::CNT_W'($urandom_range(0, 300));
          1: base[i] = tkbcd_pkg::CNT_W'($urandom_range(1000, 20000));
          2: base[i] = tkbcd_pkg::CNT_W'($urandom_range(60000, 65535));
          default: base[i] = tkbcd_pkg::CNT_W'($urandom_range(0, 65535));
        endcase
      end

      // cap the run so a large leftover frame count cannot eat the budget;
      // at most one restart per session starts the run over
      runs = (int'(cal_frames) < 100) ? int'(cal_frames) : 100;
      broke_off = 1'b0;
      for (int k = 0; k < runs; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4 && !broke_off) begin
          send_frame(random_frame(OP_RESTART));
          broke_off = 1'b1;
          k = -1;
        end else if (r < 8) begin
          send_frame(random_frame(OP_SAMPLE));
        end else begin
          send_frame(around_base(base));
        end
      end
      repeat ($urandom_range(3, 14)) send_frame(probe_frame());
    end
    burst_mode = 1'b0;
  endtask

  // Receiver holds off long enough for the block to back up and stall its input,
  // then the sender waits for every result before going on.
  task automatic test_output_hold();
    settle_idle();
    hold_request = HOLD_CYCLES;
    repeat (40) begin
      send_frame(random_frame(($urandom_range(0, 9) == 0) ? OP_RESTART : OP_SAMPLE));
    end
    settle_idle();
    repeat (10) send_frame(probe_frame());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stall runs, a long hold on request, none in burst mode
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_left--;
    end else if (hold_request > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left = hold_request - 1;
      hold_request = 0;
    end else if (burst_mode) begin
      out_stall_i <= 1'b0;
      rx_run_left = 0;
    end else begin
      if (rx_run_left == 0) begin
        rx_stalling = ($urandom_range(0, 99) < 30);
        rx_run_left = rx_stalling ? pick_gap() + 1 : $urandom_range(1, 10);
      end
      out_stall_i <= rx_stalling;
      rx_run_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each accepted word with the oldest queued key word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    key_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("result word with none pending: key %0d cal %0b done %0b",
                                  key_index_o, calibrating_o, calib_done_o));
      end else begin
        want = pending_keys.pop_front();
        if (key_index_o !== want.key)
          report_mismatch($sformatf("key_index %0d, want %0d", key_index_o, want.key));
        if (calibrating_o !== want.calibrating)
          report_mismatch($sformatf("calibrating %0b, want %0b", calibrating_o,
                                    want.calibrating));
        if (calib_done_o !== want.done)
          report_mismatch($sformatf("calib_done %0b, want %0b", calib_done_o, want.done));
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d words pending",
               WATCHDOG_LIMIT, pending_keys.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests, drain, give the verdict
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_SAMPLE;
    count_0_i   = '0;
    count_1_i   = '0;
    count_2_i   = '0;
    count_3_i   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_corner_frames();
    test_random_sessions(1700);
    test_output_hold();

    // drain, then leave room for any stray word after the last expected one
    settle_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
